// File: sv/sliding_median_deviation_sum_core_macros.svh
`ifndef SLIDING_MEDIAN_DEVIATION_SUM_CORE_MACROS_SVH
`define SLIDING_MEDIAN_DEVIATION_SUM_CORE_MACROS_SVH

// Check that holds at every edge outside reset.
`define SMD_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("smd assertion failed");

// Check that a condition at one edge implies another at the next edge.
`define SMD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("smd assertion failed");

`endif

// File: sv/smd_pkg.sv
package smd_pkg;

  localparam int SMD_MAX_WINDOW  = 64;
  localparam int SMD_SAMPLE_BITS = 16;

  // Configuration register file
  localparam int SMD_LEN_BITS  = 7;
  localparam int SMD_ADDR_BITS = 3;
  localparam int SMD_DATA_BITS = 32;
  localparam logic [SMD_LEN_BITS-1:0] SMD_LEN_RESET = 7'd8;

  typedef enum logic {
    SMD_REG_WINDOW_LEN = 1'b0
  } smd_reg_e;

  // Control that travels with a sample from the ring stage to the sort stage
  typedef struct packed {
    logic vld;   // stage holds a sample
    logic rm;    // window is full: drop the oldest sample
    logic emit;  // window is full after this sample: a result follows
  } smd_step_t;

endpackage

// File: sv/sliding_median_deviation_sum_core.sv
// Channel   Direction  Handshake                     Payload
// sample    in         sample_valid_i/sample_stall_o sample_i (signed)
// cost      out        cost_valid_o/cost_stall_i     cost_o (unsigned)
// config    in/out     psel/penable/pwrite/pready    paddr, pwdata, prdata
//
// One sample per cycle while no result is held under cost_stall_i; a result
// passes through the ring read register, the sorted cell register and the
// output register in a row.
// Reset empties the window and sets the window length to 8.
// A result held under cost_stall_i freezes all three stages and raises
// sample_stall_o; a window length write empties the window.
module sliding_median_deviation_sum_core
  import smd_pkg::*;
#(
  parameter int MaxWindow  = SMD_MAX_WINDOW,
  parameter int SampleBits = SMD_SAMPLE_BITS,
  localparam int LW = $clog2(MaxWindow + 1),
  localparam int SW = SampleBits + $clog2(MaxWindow) + 1,
  localparam int CW = SampleBits + $clog2(MaxWindow)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         sample_valid_i,
  output logic                         sample_stall_o,
  input  logic signed [SampleBits-1:0] sample_i,
  output logic                         cost_valid_o,
  input  logic                         cost_stall_i,
  output logic [CW-1:0]                cost_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [SMD_ADDR_BITS-1:0]     paddr,
  input  logic [SMD_DATA_BITS-1:0]     pwdata,
  output logic [SMD_DATA_BITS-1:0]     prdata,
  output logic                         pready
);

  logic [SMD_LEN_BITS-1:0] win_len_q;
  logic                    cfg_wr, len_wr;
  logic [LW-1:0]           eff_len, half;
  logic [LW:0]             eff_p1;
  logic                    adv;

  smd_step_t                    step;
  logic signed [SampleBits-1:0] x_s, r_s, med;
  logic signed [SW-1:0]         lsum, ssum;
  logic                         res_vld;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    len_wr = 1'b0;
    unique case (smd_reg_e'(paddr[SMD_ADDR_BITS-1]))
      SMD_REG_WINDOW_LEN: len_wr = cfg_wr;
      default:            len_wr = 1'b0;
    endcase
  end

  always_comb begin
    prdata = '0;
    unique case (smd_reg_e'(paddr[SMD_ADDR_BITS-1]))
      SMD_REG_WINDOW_LEN: prdata = SMD_DATA_BITS'(win_len_q);
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_len_q <= SMD_LEN_RESET;
    end else if (len_wr) begin
      win_len_q <= pwdata[SMD_LEN_BITS-1:0];
    end
  end

  // zero acts as one, anything above the store acts as the store size
  always_comb begin
    if (win_len_q == '0) begin
      eff_len = LW'(1);
    end else if (32'(win_len_q) > 32'(MaxWindow)) begin
      eff_len = LW'(MaxWindow);
    end else begin
      eff_len = LW'(win_len_q);
    end
  end

  assign eff_p1 = {1'b0, eff_len} + (LW+1)'(1);
  assign half   = eff_p1[LW:1];

  // hold everything while a result waits on a stalled output
  assign adv            = !(cost_valid_o && cost_stall_i);
  assign sample_stall_o = !adv;

  smd_ring #(
    .MaxWindow  (MaxWindow),
    .SampleBits (SampleBits)
  ) u_ring (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .adv_i          (adv),
    .clr_i          (len_wr),
    .len_i          (eff_len),
    .sample_valid_i (sample_valid_i),
    .sample_i       (sample_i),
    .step_o         (step),
    .x_o            (x_s),
    .r_o            (r_s)
  );

  smd_sort_chain #(
    .MaxWindow  (MaxWindow),
    .SampleBits (SampleBits)
  ) u_chain (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .clr_i     (len_wr),
    .len_i     (eff_len),
    .half_i    (half),
    .step_i    (step),
    .x_i       (x_s),
    .r_i       (r_s),
    .med_o     (med),
    .lsum_o    (lsum),
    .ssum_o    (ssum),
    .res_vld_o (res_vld)
  );

  smd_cost #(
    .MaxWindow  (MaxWindow),
    .SampleBits (SampleBits)
  ) u_cost (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .odd_i        (eff_len[0]),
    .res_vld_i    (res_vld),
    .med_i        (med),
    .lsum_i       (lsum),
    .ssum_i       (ssum),
    .cost_valid_o (cost_valid_o),
    .cost_o       (cost_o)
  );

endmodule

// File: sv/smd_ring.sv
module smd_ring
  import smd_pkg::*;
#(
  parameter int MaxWindow  = SMD_MAX_WINDOW,
  parameter int SampleBits = SMD_SAMPLE_BITS,
  localparam int LW = $clog2(MaxWindow + 1),
  localparam int IW = $clog2(MaxWindow)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         adv_i,
  input  logic                         clr_i,
  input  logic [LW-1:0]                len_i,
  input  logic                         sample_valid_i,
  input  logic signed [SampleBits-1:0] sample_i,
  output smd_step_t                    step_o,
  output logic signed [SampleBits-1:0] x_o,
  output logic signed [SampleBits-1:0] r_o
);

  logic signed [SampleBits-1:0] ring_mem [MaxWindow];
  logic signed [SampleBits-1:0] x_q, r_q;
  logic [IW-1:0] wp_q, wp_d;
  logic [LW-1:0] fill_q, fill_d;
  smd_step_t     step_q, step_d;
  logic          acc;
  logic          full;

  assign acc  = sample_valid_i && adv_i;
  assign full = (fill_q >= len_i);

  always_comb begin
    wp_d   = wp_q;
    fill_d = fill_q;
    step_d = step_q;
    if (adv_i) begin
      step_d.vld  = acc;
      step_d.rm   = full;
      step_d.emit = full || ((fill_q + LW'(1)) == len_i);
    end
    if (acc) begin
      // wrap the ring at the current window length
      if ((LW'(wp_q) + LW'(1)) == len_i) begin
        wp_d = '0;
      end else begin
        wp_d = wp_q + IW'(1);
      end
      if (!full) begin
        fill_d = fill_q + LW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      fill_q <= '0;
      step_q <= '0;
    end else if (clr_i) begin
      wp_q   <= '0;
      fill_q <= '0;
      step_q <= '0;
    end else begin
      wp_q   <= wp_d;
      fill_q <= fill_d;
      step_q <= step_d;
    end
  end

  // read the oldest sample before the slot is overwritten
  always_ff @(posedge clk_i) begin
    if (acc) begin
      r_q           <= ring_mem[wp_q];
      ring_mem[wp_q] <= sample_i;
      x_q           <= sample_i;
    end
  end

  assign step_o = step_q;
  assign x_o    = x_q;
  assign r_o    = r_q;

endmodule

// File: sv/smd_sort_chain.sv
`include "sliding_median_deviation_sum_core_macros.svh"

module smd_sort_chain
  import smd_pkg::*;
#(
  parameter int MaxWindow  = SMD_MAX_WINDOW,
  parameter int SampleBits = SMD_SAMPLE_BITS,
  localparam int LW = $clog2(MaxWindow + 1),
  localparam int SW = SampleBits + $clog2(MaxWindow) + 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         adv_i,
  input  logic                         clr_i,
  input  logic [LW-1:0]                len_i,
  input  logic [LW-1:0]                half_i,
  input  smd_step_t                    step_i,
  input  logic signed [SampleBits-1:0] x_i,
  input  logic signed [SampleBits-1:0] r_i,
  output logic signed [SampleBits-1:0] med_o,
  output logic signed [SW-1:0]         lsum_o,
  output logic signed [SW-1:0]         ssum_o,
  output logic                         res_vld_o
);

  logic signed [SampleBits-1:0] cell_q   [MaxWindow];
  logic signed [SampleBits-1:0] cell_d   [MaxWindow];
  logic signed [SampleBits-1:0] a_val    [MaxWindow];
  logic signed [SampleBits-1:0] nxt_val  [MaxWindow];
  logic signed [SampleBits-1:0] prv_val  [MaxWindow];
  logic [MaxWindow-1:0] vld, lt_r, nxt_vld, a_vld, aleq, prv_le;

  logic [LW-1:0]        fill_q;
  logic signed [SW-1:0] lsum_q, lsum_d, ssum_q, ssum_d;
  logic                 res_vld_q;

  logic signed [SampleBits-1:0] c_h, am1, med, c_hm, am1m;
  logic                         c_h_v, am1_v, lt_h1, aleq_h1;
  logic [LW-1:0]                hm1;
  logic signed [SW-1:0]         xe, re, che, ame;
  logic                         step_go;

  assign step_go = adv_i && step_i.vld;
  assign hm1     = half_i - LW'(1);

  // Each cell picks from itself, its neighbors or the new sample. A is the
  // list with the oldest sample taken out; the new sample lands after every
  // entry of A that is not above it.
  for (genvar g = 0; g < MaxWindow; g++) begin : g_cell
    assign vld[g]  = (LW'(g) < fill_q);
    assign lt_r[g] = !step_i.rm || (vld[g] && (cell_q[g] < r_i));

    if (g == MaxWindow - 1) begin : g_last
      assign nxt_val[g] = '0;
      assign nxt_vld[g] = 1'b0;
    end else begin : g_mid
      assign nxt_val[g] = cell_q[g+1];
      assign nxt_vld[g] = vld[g+1];
    end

    assign a_val[g] = lt_r[g] ? cell_q[g] : nxt_val[g];
    assign a_vld[g] = lt_r[g] ? vld[g]    : nxt_vld[g];
    assign aleq[g]  = a_vld[g] && (a_val[g] <= x_i);

    if (g == 0) begin : g_first
      assign prv_le[g]  = 1'b1;
      assign prv_val[g] = '0;
    end else begin : g_rest
      assign prv_le[g]  = aleq[g-1];
      assign prv_val[g] = a_val[g-1];
    end

    assign cell_d[g] = aleq[g] ? a_val[g] : (prv_le[g] ? x_i : prv_val[g]);
  end

  // pick the entries at the half boundary
  always_comb begin
    c_h     = '0;
    c_h_v   = 1'b0;
    am1     = '0;
    am1_v   = 1'b0;
    lt_h1   = 1'b1;
    aleq_h1 = 1'b0;
    med     = '0;
    for (int i = 0; i < MaxWindow; i++) begin
      if (LW'(i) == half_i) begin
        c_h   = cell_q[i];
        c_h_v = vld[i];
      end
      if (LW'(i) == hm1) begin
        am1     = a_val[i];
        am1_v   = a_vld[i];
        lt_h1   = lt_r[i];
        aleq_h1 = aleq[i];
        med     = cell_q[i];
      end
    end
  end

  assign c_hm = c_h_v ? c_h : '0;
  assign am1m = am1_v ? am1 : '0;
  assign xe   = SW'(x_i);
  assign re   = SW'(r_i);
  assign che  = SW'(c_hm);
  assign ame  = SW'(am1m);

  // Removal below the boundary pulls the first upper entry down; insertion
  // below the boundary pushes the last lower entry up.
  assign lsum_d = lsum_q + (lt_h1 ? SW'(0) : (che - re)) + (aleq_h1 ? SW'(0) : (xe - ame));
  assign ssum_d = ssum_q + xe - (step_i.rm ? re : SW'(0));

  always_ff @(posedge clk_i) begin
    if (step_go) begin
      cell_q <= cell_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q    <= '0;
      lsum_q    <= '0;
      ssum_q    <= '0;
      res_vld_q <= 1'b0;
    end else if (clr_i) begin
      fill_q    <= '0;
      lsum_q    <= '0;
      ssum_q    <= '0;
      res_vld_q <= 1'b0;
    end else if (adv_i) begin
      res_vld_q <= step_i.vld && step_i.emit;
      if (step_i.vld) begin
        lsum_q <= lsum_d;
        ssum_q <= ssum_d;
        if (!step_i.rm) begin
          fill_q <= fill_q + LW'(1);
        end
      end
    end
  end

  assign med_o     = med;
  assign lsum_o    = lsum_q;
  assign ssum_o    = ssum_q;
  assign res_vld_o = res_vld_q;

  `SMD_ASSERT(a_fill_in_window, fill_q <= len_i)
  `SMD_ASSERT(a_result_on_full, !res_vld_q || (fill_q == len_i))
  `SMD_ASSERT_NEXT(a_fill_steady, step_go && step_i.rm && !clr_i, fill_q == $past(fill_q))

endmodule

// File: sv/smd_cost.sv
module smd_cost
  import smd_pkg::*;
#(
  parameter int MaxWindow  = SMD_MAX_WINDOW,
  parameter int SampleBits = SMD_SAMPLE_BITS,
  localparam int SW = SampleBits + $clog2(MaxWindow) + 1,
  localparam int CW = SampleBits + $clog2(MaxWindow)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         adv_i,
  input  logic                         odd_i,
  input  logic                         res_vld_i,
  input  logic signed [SampleBits-1:0] med_i,
  input  logic signed [SW-1:0]         lsum_i,
  input  logic signed [SW-1:0]         ssum_i,
  output logic                         cost_valid_o,
  output logic [CW-1:0]                cost_o
);

  logic signed [SW-1:0] mede, dev;
  logic                 vld_q;
  logic [CW-1:0]        cost_q;

  assign mede = SW'(med_i);
  // upper minus lower, plus the median when the length is odd, where upper is the total less the lower half
  assign dev  = ssum_i - lsum_i - lsum_i + (odd_i ? mede : SW'(0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (adv_i) begin
      vld_q <= res_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && res_vld_i) begin
      cost_q <= dev[CW-1:0];
    end
  end

  assign cost_valid_o = vld_q;
  assign cost_o       = cost_q;

endmodule

// File: bench/tb_sliding_median_deviation_sum_core.sv
`timescale 1ns / 100ps

module tb_sliding_median_deviation_sum_core
  import smd_pkg::*;
;

  localparam int CostBits     = SMD_SAMPLE_BITS + $clog2(SMD_MAX_WINDOW);
  localparam int IdleLimit    = 3000;
  localparam int SettleCycles = 8;
  localparam int HoldCycles   = 50;
  localparam logic [SMD_ADDR_BITS-1:0] LenAddr =
      SMD_ADDR_BITS'(4 * int'(SMD_REG_WINDOW_LEN));
  // first byte address past the register list
  localparam logic [SMD_ADDR_BITS-1:0] PastRegsAddr =
      SMD_ADDR_BITS'(4 * (int'(SMD_REG_WINDOW_LEN) + 1));

  typedef logic signed [SMD_SAMPLE_BITS-1:0] sample_t;
  typedef logic [CostBits-1:0] cost_t;

  logic                       clk_i;
  logic                       rst_ni         = 1'b0;
  logic                       sample_valid_i = 1'b0;
  logic                       sample_stall_o;
  sample_t                    sample_i       = '0;
  logic                       cost_valid_o;
  logic                       cost_stall_i   = 1'b0;
  cost_t                      cost_o;
  logic                       psel           = 1'b0;
  logic                       penable        = 1'b0;
  logic                       pwrite         = 1'b0;
  logic [SMD_ADDR_BITS-1:0]   paddr          = '0;
  logic [SMD_DATA_BITS-1:0]   pwdata         = '0;
  logic [SMD_DATA_BITS-1:0]   prdata;
  logic                       pready;

  // receiver and sender idling controls
  logic tx_idle_en = 1'b1;
  logic rx_idle_en = 1'b1;
  logic rx_quiet   = 1'b0;
  logic rx_hold    = 1'b0;

  // predictor state
  logic [SMD_LEN_BITS-1:0] window_len_q = SMD_LEN_RESET;
  int                      ring_hist [SMD_MAX_WINDOW];
  int                      sorted_vals [$];
  int unsigned             ring_ptr = 0;
  cost_t                   expected_costs [$];

  int unsigned error_cnt     = 0;
  int unsigned samples_sent  = 0;
  int unsigned costs_checked = 0;
  int unsigned len_writes    = 0;
  int unsigned in_stall_seen = 0;
  int unsigned idle_cycles   = 0;
  int unsigned rx_burst_left = 0;
  sample_t     last_sample   = '0;

  sliding_median_deviation_sum_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .sample_valid_i(sample_valid_i),
    .sample_stall_o(sample_stall_o),
    .sample_i      (sample_i),
    .cost_valid_o  (cost_valid_o),
    .cost_stall_i  (cost_stall_i),
    .cost_o        (cost_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d, expected %0d (t=%0t)", what, got, want, $realtime);
    error_cnt++;
  endtask

  function automatic int unsigned active_span();
    if (window_len_q == 0) return 1;
    if (window_len_q > SMD_MAX_WINDOW) return SMD_MAX_WINDOW;
    return window_len_q;
  endfunction

  task automatic empty_window();
    ring_ptr = 0;
    sorted_vals.delete();
  endtask

  // advance the window by one sample and queue the cost it yields, if any
  task automatic predict_cost(input sample_t s);
    int unsigned span;
    int unsigned half;
    int          idx;
    int          med;
    longint      acc;
    span = active_span();
    if (ring_ptr >= span) ring_ptr = 0;
    if (sorted_vals.size() >= span) begin
      for (idx = 0; idx < sorted_vals.size(); idx++) begin
        if (sorted_vals[idx] == ring_hist[ring_ptr]) begin
          sorted_vals.delete(idx);
          break;
        end
      end
    end
    ring_hist[ring_ptr] = int'(s);
    ring_ptr = (ring_ptr + 1) % span;
    idx = 0;
    while (idx < sorted_vals.size() && sorted_vals[idx] <= int'(s)) idx++;
    sorted_vals.insert(idx, int'(s));
    if (sorted_vals.size() >= span) begin
      half = (span + 1) / 2;
      med  = sorted_vals[half-1];
      acc  = 0;
      foreach (sorted_vals[i]) begin
        acc += (sorted_vals[i] >= med) ? longint'(sorted_vals[i] - med)
                                       : longint'(med - sorted_vals[i]);
      end
      expected_costs.push_back(acc[CostBits-1:0]);
    end
  endtask

  // receiver: random stall bursts, long hold on request, quiet while settling
  always @(posedge clk_i) begin
    if (rx_hold) begin
      cost_stall_i <= 1'b1;
    end else if (rx_quiet || !rx_idle_en) begin
      cost_stall_i  <= 1'b0;
      rx_burst_left = 0;
    end else if (rx_burst_left > 0) begin
      cost_stall_i <= 1'b1;
      rx_burst_left--;
    end else if ($urandom_range(0, 99) < 15) begin
      cost_stall_i  <= 1'b1;
      rx_burst_left = $urandom_range(0, 6);
    end else begin
      cost_stall_i <= 1'b0;
    end
  end

  // compare each cost transaction with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && cost_valid_o && !cost_stall_i) begin
      if (expected_costs.size() == 0) begin
        report_mismatch("cost with nothing pending", cost_o, -1);
      end else begin
        if (cost_o !== expected_costs[0])
          report_mismatch("cost", cost_o, expected_costs[0]);
        void'(expected_costs.pop_front());
        costs_checked++;
      end
    end
    if (rst_ni && sample_valid_i && sample_stall_o) in_stall_seen++;
  end

  always @(posedge clk_i) begin
    if ((sample_valid_i && !sample_stall_o) || (cost_valid_o && !cost_stall_i) ||
        (psel && penable && pready) || !rst_ni) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("watchdog: no transaction for %0d cycles", IdleLimit);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic send_sample(input sample_t s);
    sample_valid_i <= 1'b1;
    sample_i       <= s;
    do @(posedge clk_i); while (sample_stall_o);
    predict_cost(s);
    samples_sent++;
  endtask

  task automatic sender_gap(input int unsigned cycles);
    sample_valid_i <= 1'b0;
    sample_i       <= sample_t'($urandom());
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic feed_sample(input sample_t s);
    if (tx_idle_en && $urandom_range(0, 99) < 12) sender_gap($urandom_range(1, 7));
    send_sample(s);
  endtask

  task automatic wait_results_drained();
    sample_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_costs.size() != 0);
  endtask

  // drain, then give samples that yield no cost time to leave the pipeline
  task automatic settle_block();
    wait_results_drained();
    rx_quiet <= 1'b1;
    repeat (SettleCycles) @(posedge clk_i);
    rx_quiet <= 1'b0;
  endtask

  task automatic apb_write(input logic [SMD_ADDR_BITS-1:0] addr,
                           input logic [SMD_DATA_BITS-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == LenAddr) begin
      window_len_q = data[SMD_LEN_BITS-1:0];
      empty_window();
      len_writes++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // idle the bus before the next transfer
    @(posedge clk_i);
  endtask

  task automatic check_len_readback();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= LenAddr;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== SMD_DATA_BITS'(window_len_q))
      report_mismatch("window_len readback", prdata, window_len_q);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_window_len(input logic [SMD_LEN_BITS-1:0] len);
    logic [SMD_DATA_BITS-1:0] word;
    word = SMD_DATA_BITS'(len);
    // stray upper bits must be dropped by the register
    if ($urandom_range(0, 1)) word = ($urandom() & ~32'h7F) | word;
    settle_block();
    apb_write(LenAddr, word);
    check_len_readback();
  endtask

  function automatic sample_t pick_sample();
    sample_t s;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: s = sample_t'($urandom());
      4, 5:       s = sample_t'($urandom_range(0, 15)) - sample_t'(8);
      6:          s = $urandom_range(0, 1) ? sample_t'(16'sh7FFF) : sample_t'(16'sh8000);
      7:          s = last_sample;
      default:    s = sample_t'($urandom_range(0, 4095)) - sample_t'(2048);
    endcase
    last_sample = s;
    return s;
  endfunction

  task automatic test_reset_state();
    sample_t seq [] = '{16'sh8000, 16'sh7FFF, 16'sh0000, -16'sd1, 16'sd1,
                        16'sh8000, 16'sh7FFF, 16'sd100, 16'sh7FFF, 16'sh8000};
    check_len_readback();
    foreach (seq[i]) send_sample(seq[i]);
  endtask

  task automatic test_short_windows();
    sample_t one [] = '{16'sh7FFF, 16'sh8000, 16'sh0000};
    sample_t three [] = '{16'sd5, 16'sd5, 16'sd5, 16'sd5, -16'sd7};
    set_window_len(7'd1);
    foreach (one[i]) send_sample(one[i]);
    // zero length behaves as one
    set_window_len(7'd0);
    send_sample(-16'sd1);
    send_sample(16'sd12345);
    // duplicates: dropping the oldest must remove exactly one equal entry
    set_window_len(7'd3);
    foreach (three[i]) send_sample(three[i]);
    // a write past the register list leaves the window intact
    settle_block();
    apb_write(PastRegsAddr, 32'd1);
    check_len_readback();
    send_sample(16'sd9);
    send_sample(16'sd9);
  endtask

  task automatic test_backpressure();
    set_window_len(7'd4);
    fork
      begin
        rx_hold <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        rx_hold <= 1'b0;
      end
      begin
        repeat (40) send_sample(pick_sample());
      end
    join
  endtask

  task automatic test_random_windows();
    logic [SMD_LEN_BITS-1:0] lens [] = '{7'd64, 7'd127, 7'd2, 7'd1, 7'd0,
                                         7'd65, 7'd33, 7'd8, 7'd5, 7'd0};
    int unsigned n_items;
    foreach (lens[i]) begin
      if (i == lens.size() - 1) begin
        // final phase: no idling on either side
        lens[i] = SMD_LEN_BITS'($urandom_range(3, 20));
        wait_results_drained();
        tx_idle_en <= 1'b0;
        rx_idle_en <= 1'b0;
      end
      set_window_len(lens[i]);
      n_items = active_span() + 40;
      for (int k = 0; k < n_items; k++) begin
        // pause the stream until every pending cost is out
        if (k == n_items / 2) wait_results_drained();
        feed_sample(pick_sample());
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_short_windows();
    test_backpressure();
    test_random_windows();
    wait_results_drained();
    repeat (SettleCycles + 2) @(posedge clk_i);
    if (expected_costs.size() != 0)
      report_mismatch("costs left pending", expected_costs.size(), 0);
    $display("Covered %0d samples and %0d costs over %0d window-length writes,",
             samples_sent, costs_checked, len_writes);
    $display("lengths 0..127 incl. clamping, with %0d input-stall cycles under hold.",
             in_stall_seen);
    if (error_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
